// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int CLASS_W     = 2;
  localparam int TAG_BITS    = 16;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_GRANTED  = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    OP_ENQUEUE = 1'b0,
    OP_GRANT   = 1'b1
  } op_t;

  localparam logic [CLASS_W-1:0] CLASS_URGENT = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_NORMAL = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_OTHER  = 2'd2;

endpackage

// ===== rtl/spq_ram.sv =====
module spq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/strict_priority_three_queue_scheduler.sv =====
// Each result is strobed on done in the cycle after its request is taken.
// Throughput: one request per cycle; busy stays low, so start is never refused.
// Grants read the shared tag RAM at the head slot; the registered read sets the latency.
// The receiver cannot stall: each result is valid for exactly one cycle.
// Synchronous reset empties all three queues; the tag RAM itself is not cleared.
module strict_priority_three_queue_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_WIDTH   = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         op,
  input  logic [spq_pkg::CLASS_W-1:0]  req_class,
  input  logic [spq_pkg::TAG_BITS-1:0] tag,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [spq_pkg::CLASS_W-1:0]  grant_class,
  output logic [spq_pkg::TAG_BITS-1:0] grant_tag
);

  localparam int IW        = $clog2(QUEUE_DEPTH);
  localparam int DEPTH_ALL = spq_pkg::NUM_CLASSES * QUEUE_DEPTH;
  localparam int AW        = $clog2(DEPTH_ALL);
  localparam int SW        = (TAG_WIDTH < spq_pkg::TAG_BITS) ? TAG_WIDTH : spq_pkg::TAG_BITS;
  localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);

  logic [IW-1:0] head [spq_pkg::NUM_CLASSES];
  logic [IW-1:0] tail [spq_pkg::NUM_CLASSES];
  logic [IW-1:0] head_next [spq_pkg::NUM_CLASSES];
  logic [IW-1:0] tail_next [spq_pkg::NUM_CLASSES];
  logic [spq_pkg::NUM_CLASSES-1:0] nonempty, nonempty_next;

  logic                        accept;
  logic [spq_pkg::CLASS_W-1:0] enq_q;
  logic [spq_pkg::CLASS_W-1:0] grant_q;
  logic                        grant_found;
  logic [IW-1:0]               enq_slot;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;
  logic [SW-1:0]               rdata;
  spq_pkg::status_t            res_status_next, res_status;
  logic [spq_pkg::CLASS_W-1:0] res_class_next, res_class;

  function automatic logic [AW-1:0] slot_addr(input logic [spq_pkg::CLASS_W-1:0] q,
                                              input logic [IW-1:0] idx);
    return AW'(q) * AW'(QUEUE_DEPTH) + AW'(idx);
  endfunction

  // Every request is finished in a single pass, so the block is never busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Any class code other than urgent or normal falls into the other queue.
  assign enq_q = (req_class == spq_pkg::CLASS_URGENT || req_class == spq_pkg::CLASS_NORMAL) ?
                 req_class : spq_pkg::CLASS_OTHER;

  // Lowest class index wins, so scan from the bottom of the priority order upwards.
  always_comb begin
    grant_q     = spq_pkg::CLASS_URGENT;
    grant_found = 1'b0;
    for (int i = spq_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        grant_q     = spq_pkg::CLASS_W'(i);
        grant_found = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < spq_pkg::NUM_CLASSES; i++) begin
      head_next[i] = head[i];
      tail_next[i] = tail[i];
    end
    nonempty_next   = nonempty;
    we              = 1'b0;
    enq_slot        = tail[enq_q] + IW'(1);
    res_status_next = spq_pkg::ST_NONE;
    res_class_next  = spq_pkg::CLASS_URGENT;
    if (accept) begin
      if (op == spq_pkg::OP_ENQUEUE) begin
        if (!nonempty[enq_q]) begin
          head_next[enq_q]     = '0;
          tail_next[enq_q]     = '0;
          nonempty_next[enq_q] = 1'b1;
          enq_slot             = '0;
          we                   = 1'b1;
          res_status_next      = spq_pkg::ST_ENQUEUED;
        end else if (tail[enq_q] == LAST_SLOT) begin
          // Slots freed by earlier grants are not reused until the queue drains.
          res_status_next = spq_pkg::ST_FULL;
        end else begin
          tail_next[enq_q] = enq_slot;
          we               = 1'b1;
          res_status_next  = spq_pkg::ST_ENQUEUED;
        end
      end else if (grant_found) begin
        res_status_next = spq_pkg::ST_GRANTED;
        res_class_next  = grant_q;
        if (head[grant_q] == tail[grant_q]) begin
          head_next[grant_q]     = '0;
          tail_next[grant_q]     = '0;
          nonempty_next[grant_q] = 1'b0;
        end else begin
          head_next[grant_q] = head[grant_q] + IW'(1);
        end
      end
    end
  end

  assign waddr = slot_addr(enq_q, enq_slot);
  assign raddr = slot_addr(grant_q, head[grant_q]);

  spq_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH_ALL)
  ) u_spq_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (tag[SW-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < spq_pkg::NUM_CLASSES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
      nonempty <= '0;
      done     <= 1'b0;
    end else begin
      for (int i = 0; i < spq_pkg::NUM_CLASSES; i++) begin
        head[i] <= head_next[i];
        tail[i] <= tail_next[i];
      end
      nonempty <= nonempty_next;
      done     <= accept;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_class  <= res_class_next;
  end

  assign status      = res_status;
  assign grant_class = res_class;
  assign grant_tag   = (res_status == spq_pkg::ST_GRANTED) ?
                       spq_pkg::TAG_BITS'(rdata) : '0;

endmodule

// ===== rtl/spq_checker.sv =====
`include "assert_macros.svh"

module spq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         op,
  input logic [spq_pkg::CLASS_W-1:0]  req_class,
  input logic [spq_pkg::TAG_BITS-1:0] tag,
  input logic                         done,
  input logic [1:0]                   status,
  input logic [spq_pkg::CLASS_W-1:0]  grant_class,
  input logic [spq_pkg::TAG_BITS-1:0] grant_tag
);

  logic accept;
  assign accept = start && !busy;

  // Exactly one result follows each accepted request, in the next cycle.
  `ASSERT_NEXT(a_result_follows, accept, done)
  `ASSERT_NEXT(a_no_spurious_result, !accept, !done)

  // Only a grant request may produce a grant or an empty report.
  `ASSERT_SAME(a_status_matches_op, done,
               ((status == spq_pkg::ST_ENQUEUED || status == spq_pkg::ST_FULL) ==
                ($past(op) == spq_pkg::OP_ENQUEUE)))

  // Non-grant results carry zeroed grant fields.
  `ASSERT_SAME(a_fields_zero, done && status != spq_pkg::ST_GRANTED,
               grant_tag == '0 && grant_class == spq_pkg::CLASS_URGENT)

  // An urgent enqueue leaves the urgent queue occupied, so the next grant must succeed.
  `ASSERT_NEXT(a_grant_after_urgent,
               (accept && op == spq_pkg::OP_ENQUEUE && req_class == spq_pkg::CLASS_URGENT)
                 ##1 (accept && op == spq_pkg::OP_GRANT),
               status == spq_pkg::ST_GRANTED && grant_class == spq_pkg::CLASS_URGENT)

endmodule

bind strict_priority_three_queue_scheduler spq_checker u_spq_checker (.*);
